// File: rtl/position_spike_reject_median3_core_assert.svh
// Assertion macros shared by the checker of the position conditioner.
`ifndef POSITION_SPIKE_REJECT_MEDIAN3_CORE_ASSERT_SVH
`define POSITION_SPIKE_REJECT_MEDIAN3_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define PSRM3_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("position conditioner: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define PSRM3_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("position conditioner: next-cycle check failed");

`endif

// File: rtl/psrm3_pkg.sv
// Types, constants and helper functions of the position conditioner.
package psrm3_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int STEP_BITS      = 12;
	localparam int GAP_BITS       = (SAMPLE_BITS > STEP_BITS) ? SAMPLE_BITS : STEP_BITS;
	localparam int RING_DEPTH     = 3;
	localparam int SLOT_BITS      = 2;
	localparam int SIDES          = 2;

	localparam logic [STEP_BITS-1:0] MAX_STEP_RESET = STEP_BITS'(819);
	localparam logic [SLOT_BITS-1:0] SLOT_FIRST     = SLOT_BITS'(0);
	localparam logic [SLOT_BITS-1:0] SLOT_LAST      = SLOT_BITS'(RING_DEPTH - 1);

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SLOT_BITS-1:0]   slot_t;
	typedef logic [GAP_BITS-1:0]    gap_t;

	typedef struct packed {
		logic    side;
		sample_t sample;
	} in_item_t;

	typedef struct packed {
		sample_t filtered_position;
		logic    result_side;
	} out_item_t;

	// Median of three unsigned samples.
	function automatic sample_t mid3(sample_t x, sample_t y, sample_t z);
		sample_t lo;
		sample_t hi;
		lo = (x < y) ? x : y;
		hi = (x < y) ? y : x;
		if (z <= lo) begin
			return lo;
		end
		if (z >= hi) begin
			return hi;
		end
		return z;
	endfunction

	// Absolute difference of two samples, cast to the gap width to compare with the step limit.
	function automatic gap_t abs_gap(sample_t x, sample_t y);
		sample_t d;
		d = (x > y) ? (x - y) : (y - x);
		return GAP_BITS'(d);
	endfunction

endpackage

// File: rtl/psrm3_if.sv
// Valid/ready stream interfaces for the sample input and the filtered result.
interface psrm3_in_if import psrm3_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface psrm3_out_if import psrm3_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/position_spike_reject_median3_core.sv
// Door position conditioner: per-side spike rejection and median-of-three filter.
// An input transfer is captured in the input register; the compute stage then feeds the
// result register whenever that register is free or drains. Throughput: one item per cycle
// while the result port does not stall; the only loop is the per-side ring and slot update,
// which closes within the single compute stage between the input and result registers.
// Reset (arst_n low, asynchronous): both rings and slot indexes clear to zero,
// max_step returns to 819 and both pipeline stages empty.
module position_spike_reject_median3_core import psrm3_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 max_step_we,
	input  logic [STEP_BITS-1:0] max_step_wdata,
	psrm3_in_if.sink             sample_ch,
	psrm3_out_if.source          result_ch
);

	logic                 valid_s1;
	in_item_t             data_s1;
	logic                 valid_s2;
	out_item_t            res_s2;
	logic [STEP_BITS-1:0] max_step_q;
	sample_t              ring_q [SIDES][RING_DEPTH];
	slot_t                slot_q [SIDES];

	logic    advance;
	logic    take_in;
	logic    cur_side;
	slot_t   cur_slot;
	slot_t   rd_slot;
	slot_t   wr_slot;
	sample_t last_val;
	sample_t kept_val;
	sample_t upd_ring [RING_DEPTH];
	sample_t median;

	// Handshake: the compute stage moves on whenever the result register is free or drains.
	assign advance         = !valid_s2 || result_ch.ready;
	assign sample_ch.ready = !valid_s1 || advance;
	assign take_in         = sample_ch.valid && sample_ch.ready;

	// Spike rejection against the last stored sample of the item's side.
	assign cur_side = data_s1.side;
	assign cur_slot = slot_q[cur_side];
	assign rd_slot  = (cur_slot <= SLOT_LAST) ? cur_slot : SLOT_FIRST;
	assign last_val = ring_q[cur_side][rd_slot];
	assign kept_val = (abs_gap(data_s1.sample, last_val) > GAP_BITS'(max_step_q))
		? last_val : data_s1.sample;

	// Next ring slot, wrapping after the last entry.
	always_comb begin
		if (cur_slot > SLOT_LAST) begin
			wr_slot = SLOT_FIRST;
		end else if (cur_slot == SLOT_LAST) begin
			wr_slot = SLOT_FIRST;
		end else begin
			wr_slot = cur_slot + SLOT_BITS'(1);
		end
	end

	// Ring contents after the update, and their median.
	always_comb begin
		for (int i = 0; i < RING_DEPTH; i++) begin
			upd_ring[i] = (wr_slot == SLOT_BITS'(i)) ? kept_val : ring_q[cur_side][i];
		end
		median = mid3(upd_ring[0], upd_ring[1], upd_ring[2]);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= MAX_STEP_RESET;
		end else if (max_step_we) begin
			max_step_q <= max_step_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_s1 <= sample_ch.payload;
		end
	end

	// Ring and slot state, updated as the item leaves the compute stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SIDES; s++) begin
				slot_q[s] <= SLOT_FIRST;
				for (int i = 0; i < RING_DEPTH; i++) begin
					ring_q[s][i] <= '0;
				end
			end
		end else if (valid_s1 && advance) begin
			slot_q[cur_side]          <= wr_slot;
			ring_q[cur_side][wr_slot] <= kept_val;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2.filtered_position <= median;
			res_s2.result_side       <= cur_side;
		end
	end

	assign result_ch.valid   = valid_s2;
	assign result_ch.payload = res_s2;

endmodule

// File: rtl/psrm3_checker.sv
// Port-level checker for the position conditioner, bound to the conditioner core.
`include "position_spike_reject_median3_core_assert.svh"

module psrm3_checker import psrm3_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_payload,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_payload
);

	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	// A stalled result stays on the port unchanged.
	`PSRM3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

	// With no result waiting, the input side is always open.
	`PSRM3_ASSERT_NOW(a_in_open, !out_valid, in_ready)

	// A fresh result follows an input transfer that passed the input register and compute stage unstalled.
	`PSRM3_ASSERT_NOW(a_out_origin, $rose(out_valid), $past(in_xfer, 2))

	// That fresh result carries the side of the item that caused it.
	`PSRM3_ASSERT_NOW(a_out_side, $rose(out_valid),
		out_payload.result_side == $past(in_payload.side, 2))

endmodule

bind position_spike_reject_median3_core psrm3_checker u_psrm3_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample_ch.valid),
	.in_ready    (sample_ch.ready),
	.in_payload  (sample_ch.payload),
	.out_valid   (result_ch.valid),
	.out_ready   (result_ch.ready),
	.out_payload (result_ch.payload)
);

// File: tb/tb.sv
// Self-checking bench for the door position conditioner: directed and random sample streams.
module tb;
	import psrm3_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 107;
	localparam int SAMPLE_TOP   = (1 << SAMPLE_BITS) - 1;
	localparam int REPORT_LIMIT = 10;

	// Predicts the filtered position of each sample transfer from a private copy of both
	// channel histories and the step limit, and holds the predictions until they return.
	class median_tracker;
		sample_t     ring [2][RING_DEPTH];
		int unsigned slot [2];
		sample_t     step_limit;
		out_item_t   expected_positions [$];
		int unsigned mismatches;

		function new();
			for (int s = 0; s < 2; s++) begin
				slot[s] = 0;
				for (int k = 0; k < RING_DEPTH; k++) begin
					ring[s][k] = '0;
				end
			end
			step_limit = MAX_STEP_RESET;
			mismatches = 0;
		endfunction

		function sample_t last_sample(logic side);
			return ring[int'(side)][slot[int'(side)]];
		endfunction

		// Middle value of three, ties included.
		function sample_t middle_of(sample_t a, sample_t b, sample_t c);
			if ((a <= b && b <= c) || (c <= b && b <= a)) begin
				return b;
			end
			if ((b <= a && a <= c) || (c <= a && a <= b)) begin
				return a;
			end
			return c;
		endfunction

		// A sample too far from the last stored one is replaced by it before it enters the ring.
		function void note_sample(in_item_t item);
			int          s;
			sample_t     kept;
			sample_t     last;
			int unsigned gap;
			int unsigned nxt;
			out_item_t   want;
			s = int'(item.side);
			last = ring[s][slot[s]];
			kept = item.sample;
			gap = (kept > last) ? kept - last : last - kept;
			if (gap > step_limit) begin
				kept = last;
			end
			nxt = (slot[s] + 1) % RING_DEPTH;
			ring[s][nxt] = kept;
			slot[s] = nxt;
			want.filtered_position = middle_of(ring[s][0], ring[s][1], ring[s][2]);
			want.result_side = item.side;
			expected_positions.push_back(want);
		endfunction

		function void check_position(out_item_t got);
			out_item_t want;
			if (expected_positions.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("unexpected result: position %0d side %0d",
						got.filtered_position, got.result_side);
				end
				return;
			end
			want = expected_positions.pop_front();
			if (got.filtered_position !== want.filtered_position ||
					got.result_side !== want.result_side) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("result differs: expected position %0d side %0d, got position %0d side %0d",
						want.filtered_position, want.result_side,
						got.filtered_position, got.result_side);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 max_step_we;
	logic [STEP_BITS-1:0] max_step_wdata;
	bit                   sender_calm;
	bit                   receiver_calm;
	int unsigned          cycles = 0;

	psrm3_in_if  sample_ch ();
	psrm3_out_if result_ch ();

	median_tracker tracker = new();

	position_spike_reject_median3_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_step_we    (max_step_we),
		.max_step_wdata (max_step_wdata),
		.sample_ch      (sample_ch),
		.result_ch      (result_ch)
	);

	// Clock with a period of eight units.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Every input transfer is predicted before any result of the same edge is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				tracker.note_sample(sample_ch.payload);
			end
			if (result_ch.valid && result_ch.ready) begin
				tracker.check_position(result_ch.payload);
			end
		end
	end

	// Result side: a random stall before each transfer unless a calm stretch is on.
	initial begin
		int unsigned stall;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = receiver_calm ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
		end
	end

	// Offers one sample and returns at the edge of its transfer; valid stays high.
	task automatic send_sample(logic side, sample_t value);
		int unsigned gap;
		in_item_t    item;
		gap = sender_calm ? 0 : $urandom_range(0, 9);
		item.side = side;
		item.sample = value;
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.payload <= item;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	// Stops the input and waits until every predicted result is back and the pipeline is empty.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.expected_positions.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Only called with the block idle.
	task automatic write_step_limit(sample_t limit);
		max_step_we <= 1'b1;
		max_step_wdata <= limit;
		@(posedge clk);
		max_step_we <= 1'b0;
		tracker.step_limit = limit;
	endtask

	// Mostly samples around the last stored value, so that both held and accepted
	// steps occur; some land exactly on the limit or one beyond it, the rest are anywhere in range.
	function automatic sample_t pick_sample(logic side);
		int          last;
		int          span;
		int          v;
		int unsigned mode;
		last = int'(tracker.last_sample(side));
		span = int'(tracker.step_limit) + int'(tracker.step_limit) / 2 + 2;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			v = int'($urandom_range(0, SAMPLE_TOP));
		end else if (mode < 8) begin
			v = last + int'($urandom_range(0, 2 * span)) - span;
		end else begin
			v = int'(tracker.step_limit) + int'($urandom_range(0, 1));
			v = ($urandom_range(0, 1) != 0) ? last + v : last - v;
		end
		if (v < 0) begin
			v = 0;
		end
		if (v > SAMPLE_TOP) begin
			v = SAMPLE_TOP;
		end
		return sample_t'(v);
	endfunction

	// Main sequence: reset, directed cases, then random phases at several step limits.
	initial begin
		sample_t limit;
		logic    side;
		arst_n <= 1'b0;
		max_step_we <= 1'b0;
		max_step_wdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.payload <= '0;
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start-up from zero histories with the reset limit, and steps right at the limit.
		send_sample(1'b0, sample_t'(SAMPLE_TOP));
		send_sample(1'b1, sample_t'(819));
		send_sample(1'b1, sample_t'(1638));
		send_sample(1'b0, sample_t'(820));
		send_sample(1'b0, sample_t'(819));
		send_sample(1'b1, sample_t'(2458));
		send_sample(1'b0, sample_t'(0));
		send_sample(1'b1, sample_t'(1638));
		drain_results();

		// Zero step: only a repeat of the last stored value gets through.
		write_step_limit('0);
		send_sample(1'b0, tracker.last_sample(1'b0));
		send_sample(1'b0, tracker.last_sample(1'b0) + 1'b1);
		send_sample(1'b1, tracker.last_sample(1'b1));
		send_sample(1'b1, sample_t'(0));
		drain_results();

		// Widest step: full-scale swings are all accepted.
		write_step_limit('1);
		send_sample(1'b0, sample_t'(SAMPLE_TOP));
		send_sample(1'b0, sample_t'(0));
		send_sample(1'b1, sample_t'(SAMPLE_TOP));
		send_sample(1'b1, sample_t'(0));
		send_sample(1'b0, sample_t'(SAMPLE_TOP));
		send_sample(1'b1, sample_t'(2730));
		drain_results();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: limit = MAX_STEP_RESET;
				1: limit = '0;
				2: limit = '1;
				3: limit = sample_t'($urandom_range(1, 40));
				default: limit = sample_t'($urandom_range(0, SAMPLE_TOP));
			endcase
			write_step_limit(limit);
			sender_calm = (phase % 3 == 1);
			receiver_calm = (phase % 4 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				side = logic'($urandom_range(0, 1));
				send_sample(side, pick_sample(side));
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_positions.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
